// ===== rtl/lcts_pkg.sv =====
`default_nettype none

package lcts_pkg;

  // field widths
  localparam int unsigned DRIVE_NUM_W = 8;
  localparam int unsigned LBA_W       = 24;
  localparam int unsigned TOTAL_W     = 8;
  localparam int unsigned CYL_W       = 22;
  localparam int unsigned HEAD_W      = 8;
  localparam int unsigned SECT_W      = 6;
  localparam int unsigned STATUS_W    = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_D0_SPT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D0_HEADS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D1_SPT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D1_HEADS = 8'd3;

  localparam logic [SECT_W-1:0] SPT_RESET   = 6'd0;
  localparam logic [HEAD_W-1:0] HEADS_RESET = 8'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DRIVE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_GEOM   = 2'd2;

  // commands per request before the block pauses for the next request
  localparam logic [5:0] MAX_CMDS = 6'd33;

  // bit-serial divider: one quotient bit per cycle over the lba width
  localparam int unsigned DIV_STEPS = LBA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic                   func;
    logic [DRIVE_NUM_W-1:0] drive_number;
    logic [LBA_W-1:0]       lba_start;
    logic [TOTAL_W-1:0]     sector_total;
  } req_t;

  typedef struct packed {
    logic                direction;
    logic                drive_out;
    logic [CYL_W-1:0]    cylinder;
    logic [HEAD_W-1:0]   head_out;
    logic [SECT_W-1:0]   first_sector;
    logic [SECT_W-1:0]   chunk_count;
    logic                last;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_SECTOR,
    ST_DIV_HEAD,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lcts_req_if.sv =====
`default_nettype none

interface lcts_req_if import lcts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcts_cmd_if.sv =====
`default_nettype none

interface lcts_cmd_if import lcts_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcts_cfg_if.sv =====
`default_nettype none

interface lcts_cfg_if import lcts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lba_to_chs_track_splitter.sv =====
`default_nettype none

// channel  dir  payload                                         request moves
// req      in   func, drive_number, lba_start, sector_total     one disk transfer
// cmd      out  direction .. status (cmd_t)                     one per-track command
// cfg      in   index, data                                     one geometry register write
//
// a fresh request is accepted, its lba is split by sectors-per-track and
// the track is then split by heads (one shared bit-serial divider), then
// its commands go out one after another while cmd is not stalled.
// error results and continuations of a long request skip the divider.
// rst is synchronous: geometry returns to spt 0 / heads 2, the block goes idle.
// req is taken only when idle and the output register is free or draining.
module lba_to_chs_track_splitter import lcts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  lcts_req_if.sink   req,
  lcts_cmd_if.source cmd,
  lcts_cfg_if.sink   cfg
);

  // geometry registers
  logic [SECT_W-1:0] d0_spt, d1_spt;
  logic [HEAD_W-1:0] d0_heads, d1_heads;

  // request state
  state_t            state, state_next;
  logic [CYL_W-1:0]  cur_cylinder, cur_cylinder_next;
  logic [HEAD_W-1:0] cur_head, cur_head_next;
  logic [SECT_W-1:0] cur_sector, cur_sector_next;
  logic [TOTAL_W-1:0] remaining, remaining_next;
  logic              busy, busy_next;
  logic [1:0]        held_drive_dir, held_drive_dir_next;
  logic [5:0]        step_cnt, step_cnt_next;

  // divider registers
  logic [LBA_W-1:0]     div_dvd, div_dvd_next;
  logic [HEAD_W-1:0]    div_rem, div_rem_next;
  logic [HEAD_W-1:0]    div_dsr, div_dsr_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  // output register
  logic out_valid, out_valid_next;
  cmd_t out_data, out_data_next;

  logic in_fire, out_free;

  assign cfg.ready = 1'b1;
  assign cmd.valid = out_valid;
  assign cmd.data  = out_data;
  assign out_free  = !out_valid || cmd.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign in_fire   = req.valid && req.ready;

  // geometry write port
  always_ff @(posedge clk) begin
    if (rst) begin
      d0_spt   <= SPT_RESET;
      d0_heads <= HEADS_RESET;
      d1_spt   <= SPT_RESET;
      d1_heads <= HEADS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_D0_SPT:   d0_spt   <= cfg.data[SECT_W-1:0];
        REG_D0_HEADS: d0_heads <= cfg.data[HEAD_W-1:0];
        REG_D1_SPT:   d1_spt   <= cfg.data[SECT_W-1:0];
        REG_D1_HEADS: d1_heads <= cfg.data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry lookup for the incoming and the held drive
  logic [SECT_W-1:0] req_spt, held_spt;
  logic [HEAD_W-1:0] req_heads, held_heads;
  logic              req_geom_ok, held_geom_ok;

  assign req_spt      = req.data.drive_number[0] ? d1_spt : d0_spt;
  assign req_heads    = req.data.drive_number[0] ? d1_heads : d0_heads;
  assign held_spt     = held_drive_dir[1] ? d1_spt : d0_spt;
  assign held_heads   = held_drive_dir[1] ? d1_heads : d0_heads;
  assign req_geom_ok  = (req_spt != '0) && (req_heads != '0);
  assign held_geom_ok = (held_spt != '0) && (held_heads != '0);

  // one restoring division step
  logic [HEAD_W:0]   rem_shift, rem_sub;
  logic              quo_bit;
  logic [HEAD_W-1:0] rem_new;
  logic [LBA_W-1:0]  dvd_new;

  assign rem_shift = {div_rem, div_dvd[LBA_W-1]};
  assign quo_bit   = rem_shift >= {1'b0, div_dsr};
  assign rem_sub   = rem_shift - {1'b0, div_dsr};
  assign rem_new   = quo_bit ? rem_sub[HEAD_W-1:0] : rem_shift[HEAD_W-1:0];
  assign dvd_new   = {div_dvd[LBA_W-2:0], quo_bit};

  // chunk of the current track
  logic [SECT_W:0]    avail;
  logic [TOTAL_W-1:0] chunk, rem_after;
  logic [HEAD_W-1:0]  head_inc;
  logic               cmd_last;

  assign avail     = (cur_sector <= held_spt) ?
                     7'({1'b0, held_spt} - {1'b0, cur_sector} + 7'd1) : '0;
  assign chunk     = ({1'b0, avail} > remaining) ? remaining : {1'b0, avail};
  assign rem_after = remaining - chunk;
  assign cmd_last  = (rem_after == '0);
  assign head_inc  = cur_head + 8'd1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      busy           <= 1'b0;
      out_valid      <= 1'b0;
      cur_cylinder   <= '0;
      cur_head       <= '0;
      cur_sector     <= '0;
      remaining      <= '0;
      held_drive_dir <= '0;
      step_cnt       <= '0;
      div_cnt        <= '0;
    end else begin
      state          <= state_next;
      busy           <= busy_next;
      out_valid      <= out_valid_next;
      cur_cylinder   <= cur_cylinder_next;
      cur_head       <= cur_head_next;
      cur_sector     <= cur_sector_next;
      remaining      <= remaining_next;
      held_drive_dir <= held_drive_dir_next;
      step_cnt       <= step_cnt_next;
      div_cnt        <= div_cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    div_dvd  <= div_dvd_next;
    div_rem  <= div_rem_next;
    div_dsr  <= div_dsr_next;
    out_data <= out_data_next;
  end

  // next state and outputs
  always_comb begin
    state_next          = state;
    busy_next           = busy;
    cur_cylinder_next   = cur_cylinder;
    cur_head_next       = cur_head;
    cur_sector_next     = cur_sector;
    remaining_next      = remaining;
    held_drive_dir_next = held_drive_dir;
    step_cnt_next       = step_cnt;
    div_dvd_next        = div_dvd;
    div_rem_next        = div_rem;
    div_dsr_next        = div_dsr;
    div_cnt_next        = div_cnt;
    out_data_next       = out_data;
    out_valid_next      = out_valid && !cmd.ready;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (busy) begin
            // continue the held request, input payload is ignored
            if (!held_geom_ok) begin
              out_data_next           = '0;
              out_data_next.direction = held_drive_dir[0];
              out_data_next.drive_out = held_drive_dir[1];
              out_data_next.last      = 1'b1;
              out_data_next.status    = STATUS_NO_GEOM;
              out_valid_next          = 1'b1;
              busy_next               = 1'b0;
            end else begin
              step_cnt_next = '0;
              state_next    = ST_EMIT;
            end
          end else if (req.data.drive_number > 8'd1) begin
            out_data_next           = '0;
            out_data_next.direction = req.data.func;
            out_data_next.last      = 1'b1;
            out_data_next.status    = STATUS_BAD_DRIVE;
            out_valid_next          = 1'b1;
          end else if (!req_geom_ok) begin
            out_data_next           = '0;
            out_data_next.direction = req.data.func;
            out_data_next.drive_out = req.data.drive_number[0];
            out_data_next.last      = 1'b1;
            out_data_next.status    = STATUS_NO_GEOM;
            out_valid_next          = 1'b1;
          end else begin
            held_drive_dir_next = {req.data.drive_number[0], req.data.func};
            remaining_next      = req.data.sector_total;
            div_dvd_next        = req.data.lba_start;
            div_rem_next        = '0;
            div_dsr_next        = {2'b00, req_spt};
            div_cnt_next        = DIV_LAST_CNT;
            state_next          = ST_DIV_SECTOR;
          end
        end
      end

      ST_DIV_SECTOR: begin
        div_dvd_next = dvd_new;
        div_rem_next = rem_new;
        div_cnt_next = div_cnt - DIV_CNT_W'(1);
        if (div_cnt == '0) begin
          // quotient stays in place as the next dividend
          cur_sector_next = rem_new[SECT_W-1:0] + 6'd1;
          div_rem_next    = '0;
          div_dsr_next    = held_heads;
          div_cnt_next    = DIV_LAST_CNT;
          state_next      = ST_DIV_HEAD;
        end
      end

      ST_DIV_HEAD: begin
        div_dvd_next = dvd_new;
        div_rem_next = rem_new;
        div_cnt_next = div_cnt - DIV_CNT_W'(1);
        if (div_cnt == '0) begin
          cur_cylinder_next = dvd_new[CYL_W-1:0];
          cur_head_next     = rem_new;
          busy_next         = 1'b1;
          step_cnt_next     = '0;
          state_next        = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_data_next.direction    = held_drive_dir[0];
          out_data_next.drive_out    = held_drive_dir[1];
          out_data_next.cylinder     = cur_cylinder;
          out_data_next.head_out     = cur_head;
          out_data_next.first_sector = cur_sector;
          out_data_next.chunk_count  = chunk[SECT_W-1:0];
          out_data_next.last         = cmd_last;
          out_data_next.status       = STATUS_OK;
          out_valid_next             = 1'b1;
          remaining_next             = rem_after;
          if (cmd_last) begin
            busy_next  = 1'b0;
            state_next = ST_IDLE;
          end else begin
            // step to sector 1 of the next track
            cur_sector_next = 6'd1;
            if (head_inc >= held_heads) begin
              cur_head_next     = '0;
              cur_cylinder_next = cur_cylinder + 22'd1;
            end else begin
              cur_head_next = head_inc;
            end
            step_cnt_next = step_cnt + 6'd1;
            if (step_cnt + 6'd1 == MAX_CMDS) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  // divider runs only with an empty output register
  a_div_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_SECTOR || state == ST_DIV_HEAD) |-> !out_valid)
    else $error("output loaded during division");

  // emission only on a live request
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> busy)
    else $error("emitting while not busy");

  // error results always close the request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STATUS_OK) |-> out_data.last)
    else $error("error result without last");

  // a non-final command carries data
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_OK && !out_data.last)
      |-> (out_data.chunk_count != '0))
    else $error("empty non-final command");

  // per-request command count bound
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step_cnt <= MAX_CMDS)
    else $error("too many commands in one request");
`endif

endmodule

`default_nettype wire
